@@ sv/slpc_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the status led pattern controller
// no dependencies; used by every module of the block by scoped names

package slpc_pkg;

    // event codes carried in the action field
    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_MODE_WRITE = 3'd1,
        ACT_LINK_UP    = 3'd2,
        ACT_LINK_DOWN  = 3'd3,
        ACT_PAIR_START = 3'd4,
        ACT_PAIR_DONE  = 3'd5
    } action_t;

    // indicator modes
    typedef enum logic [1:0] {
        MODE_OFF        = 2'd0,
        MODE_OUTPUTTING = 2'd1,
        MODE_WAITING    = 2'd2
    } mode_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_STALE_TIMEOUT = 3'd0,
        REG_WAIT_SOLID    = 3'd1,
        REG_WAIT_PERIOD   = 3'd2,
        REG_WAIT_ON       = 3'd3,
        REG_IDLE_PERIOD   = 3'd4,
        REG_IDLE_ON       = 3'd5,
        REG_PAIR_PERIOD   = 3'd6
    } reg_index_t;

    // sequencer states of the top level
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_RUN,
        SEQ_DONE
    } seq_state_t;

    localparam int CFG_WIDTH    = 16;
    localparam int UPTIME_WIDTH = 32;

    // configuration reset values
    localparam logic [CFG_WIDTH-1:0] RST_STALE_TIMEOUT = 16'd6000;
    localparam logic [CFG_WIDTH-1:0] RST_WAIT_SOLID    = 16'd15000;
    localparam logic [CFG_WIDTH-1:0] RST_WAIT_PERIOD   = 16'd200;
    localparam logic [CFG_WIDTH-1:0] RST_WAIT_ON       = 16'd90;
    localparam logic [CFG_WIDTH-1:0] RST_IDLE_PERIOD   = 16'd1200;
    localparam logic [CFG_WIDTH-1:0] RST_IDLE_ON       = 16'd160;
    localparam logic [CFG_WIDTH-1:0] RST_PAIR_PERIOD   = 16'd180;

    // double blink pattern of the outputting mode
    localparam logic [CFG_WIDTH-1:0] DBL_PERIOD       = 16'd1600;
    localparam logic [CFG_WIDTH-1:0] DBL_FIRST_END    = 16'd210;
    localparam logic [CFG_WIDTH-1:0] DBL_SECOND_START = 16'd340;
    localparam logic [CFG_WIDTH-1:0] DBL_SECOND_END   = 16'd550;

    // event state seen by the sequencer
    typedef struct packed {
        logic [UPTIME_WIDTH-1:0] uptime;
        logic                    link_up;
        logic                    pairing_active;
        mode_t                   requested_mode;
        logic                    request_valid;
        logic                    write_fresh;   // since_write <= stale timeout
        logic                    change_solid;  // since_change >= waiting solid time
    } status_t;

endpackage

@@ sv/status_led_pattern_controller.sv @@
`timescale 1ns / 1ps
// top level of the status led pattern controller: config registers, sequencer, result register
// depends on slpc_pkg, slpc_state and slpc_rem
//
//   channel   direction  signals                     contents
//   s_axis    in         s_tvalid s_tready s_tdata   [2:0] action, [10:3] mode_value
//   m_axis    out        m_tvalid m_tready m_tdata   [0] led_on, [2:1] shown_mode
//   cfg       in         cfg_valid cfg_ready         cfg_index, cfg_data (16 bit)
//
// each event passes through the sequencer steps in order: start, run for the
// bit-serial remainder of uptime by the active blink period, then done, where the
// level is decided combinationally and loaded into the result register.
// reset clears control and event state and loads the register defaults; no clearing pass.
// a stalled result holds the sequencer in its final step; cfg_ready is always high.

module status_led_pattern_controller
#(
    parameter int AGE_WIDTH = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [2:0] action, [10:3] mode_value, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] led_on, [2:1] shown_mode, rest zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = slpc_pkg::CFG_WIDTH;

    logic [CW-1:0] stale_reg, solid_reg, wper_reg, won_reg, iper_reg, ion_reg, pper_reg;
    slpc_pkg::seq_state_t state_reg, state_next;
    slpc_pkg::status_t    status;
    slpc_pkg::mode_t      shown;
    logic                 in_accept;
    logic                 rem_start;
    logic                 rem_done;
    logic [CW-1:0]        rem;
    logic [CW-1:0]        divisor;
    logic                 led;
    logic                 load_out;
    logic                 m_valid_reg;
    logic                 led_reg;
    slpc_pkg::mode_t      shown_reg;

    // configuration writes, out of range indexes ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg <= slpc_pkg::RST_STALE_TIMEOUT;
            solid_reg <= slpc_pkg::RST_WAIT_SOLID;
            wper_reg  <= slpc_pkg::RST_WAIT_PERIOD;
            won_reg   <= slpc_pkg::RST_WAIT_ON;
            iper_reg  <= slpc_pkg::RST_IDLE_PERIOD;
            ion_reg   <= slpc_pkg::RST_IDLE_ON;
            pper_reg  <= slpc_pkg::RST_PAIR_PERIOD;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                slpc_pkg::REG_STALE_TIMEOUT: stale_reg <= cfg_data;
                slpc_pkg::REG_WAIT_SOLID:    solid_reg <= cfg_data;
                slpc_pkg::REG_WAIT_PERIOD:   wper_reg  <= cfg_data;
                slpc_pkg::REG_WAIT_ON:       won_reg   <= cfg_data;
                slpc_pkg::REG_IDLE_PERIOD:   iper_reg  <= cfg_data;
                slpc_pkg::REG_IDLE_ON:       ion_reg   <= cfg_data;
                slpc_pkg::REG_PAIR_PERIOD:   pper_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_accept = s_tvalid && s_tready;

    // event state
    slpc_state #(
        .AGE_WIDTH (AGE_WIDTH)
    ) u_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .action        (s_tdata[2:0]),
        .mode_value    (s_tdata[10:3]),
        .stale_timeout (stale_reg),
        .waiting_solid (solid_reg),
        .status        (status)
    );

    // effective mode
    always_comb
    begin
        if (status.link_up && status.request_valid && status.write_fresh)
            shown = status.requested_mode;
        else
            shown = slpc_pkg::MODE_OFF;
    end

    // blink period in use for the current state
    always_comb
    begin
        if (!status.link_up)
            divisor = status.pairing_active ? pper_reg : iper_reg;
        else if (shown == slpc_pkg::MODE_OUTPUTTING)
            divisor = slpc_pkg::DBL_PERIOD;
        else
            divisor = wper_reg;
    end

    slpc_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (status.uptime),
        .divisor  (divisor),
        .done     (rem_done),
        .rem      (rem)
    );

    // led level from the phase
    always_comb
    begin
        led = 1'b0;
        if (!status.link_up)
        begin
            if (status.pairing_active)
                led = rem < (pper_reg >> 1);
            else
                led = rem < ion_reg;
        end
        else
        begin
            case (shown)
                slpc_pkg::MODE_OUTPUTTING:
                    led = (rem < slpc_pkg::DBL_FIRST_END) ||
                          (rem >= slpc_pkg::DBL_SECOND_START &&
                           rem < slpc_pkg::DBL_SECOND_END);
                slpc_pkg::MODE_WAITING:
                    led = status.change_solid || (rem < won_reg);
                default:
                    led = 1'b0;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            slpc_pkg::SEQ_IDLE:  if (in_accept) state_next = slpc_pkg::SEQ_START;
            slpc_pkg::SEQ_START: state_next = slpc_pkg::SEQ_RUN;
            slpc_pkg::SEQ_RUN:   if (rem_done) state_next = slpc_pkg::SEQ_DONE;
            slpc_pkg::SEQ_DONE:  if (!m_valid_reg || m_tready) state_next = slpc_pkg::SEQ_IDLE;
            default:             state_next = slpc_pkg::SEQ_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        rem_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            slpc_pkg::SEQ_IDLE:  s_tready  = 1'b1;
            slpc_pkg::SEQ_START: rem_start = 1'b1;
            slpc_pkg::SEQ_RUN:   ;
            slpc_pkg::SEQ_DONE:  load_out  = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= slpc_pkg::SEQ_IDLE;
        else
            state_reg <= state_next;
    end

    // result register, one transaction per event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (load_out)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            led_reg   <= led;
            shown_reg <= shown;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, shown_reg, led_reg};

endmodule

@@ sv/slpc_rem.sv @@
`timescale 1ns / 1ps
// iterative remainder unit: 32-bit dividend mod 16-bit divisor, one bit per cycle
// depends on slpc_pkg for widths

module slpc_rem
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [slpc_pkg::UPTIME_WIDTH-1:0]      dividend,
    input  logic [slpc_pkg::CFG_WIDTH-1:0]         divisor,
    output logic                                   done,
    output logic [slpc_pkg::CFG_WIDTH-1:0]         rem
);

    localparam int CW = slpc_pkg::CFG_WIDTH;
    localparam int UW = slpc_pkg::UPTIME_WIDTH;
    localparam int NW = $clog2(UW);

    logic [CW-1:0] rem_reg, rem_next;
    logic [UW-1:0] dvd_reg, dvd_next;
    logic [CW-1:0] dvs_reg, dvs_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW:0]   trial;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[UW-1]};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            // a zero period acts as a period of one
            dvs_next  = (divisor == '0) ? CW'(1) : divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
                rem_next = CW'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[CW-1:0];
            dvd_next = {dvd_reg[UW-2:0], 1'b0};
            cnt_next = cnt_reg + NW'(1);
            if (cnt_reg == NW'(UW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ sv/slpc_state.sv @@
`timescale 1ns / 1ps
// event state: uptime, link and pairing flags, requested mode and the two ages
// depends on slpc_pkg for action and mode codes and the status struct

module slpc_state
#(
    parameter int AGE_WIDTH = 20
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [2:0]                          action,
    input  logic [7:0]                          mode_value,
    input  logic [slpc_pkg::CFG_WIDTH-1:0]      stale_timeout,
    input  logic [slpc_pkg::CFG_WIDTH-1:0]      waiting_solid,
    output slpc_pkg::status_t                   status
);

    logic [slpc_pkg::UPTIME_WIDTH-1:0] uptime_reg, uptime_next;
    logic [AGE_WIDTH-1:0]              since_write_reg, since_write_next;
    logic [AGE_WIDTH-1:0]              since_change_reg, since_change_next;
    logic                              link_up_reg, link_up_next;
    logic                              pairing_reg, pairing_next;
    slpc_pkg::mode_t                   req_mode_reg, req_mode_next;
    logic                              req_valid_reg, req_valid_next;
    slpc_pkg::mode_t                   clamped;

    // written byte to mode, anything but outputting or waiting is off
    always_comb
    begin
        if (mode_value == 8'(slpc_pkg::MODE_OUTPUTTING))
            clamped = slpc_pkg::MODE_OUTPUTTING;
        else if (mode_value == 8'(slpc_pkg::MODE_WAITING))
            clamped = slpc_pkg::MODE_WAITING;
        else
            clamped = slpc_pkg::MODE_OFF;
    end

    // event decode
    always_comb
    begin
        uptime_next       = uptime_reg;
        since_write_next  = since_write_reg;
        since_change_next = since_change_reg;
        link_up_next      = link_up_reg;
        pairing_next      = pairing_reg;
        req_mode_next     = req_mode_reg;
        req_valid_next    = req_valid_reg;
        if (accept)
        begin
            unique case (action)
                slpc_pkg::ACT_TICK:
                begin
                    uptime_next = uptime_reg + 32'd1;
                    if (since_write_reg != '1)
                        since_write_next = since_write_reg + AGE_WIDTH'(1);
                    if (since_change_reg != '1)
                        since_change_next = since_change_reg + AGE_WIDTH'(1);
                end
                slpc_pkg::ACT_MODE_WRITE:
                begin
                    if (!req_valid_reg || req_mode_reg != clamped)
                        since_change_next = '0;
                    req_mode_next    = clamped;
                    req_valid_next   = 1'b1;
                    since_write_next = '0;
                end
                slpc_pkg::ACT_LINK_UP:
                begin
                    link_up_next      = 1'b1;
                    req_mode_next     = slpc_pkg::MODE_OFF;
                    req_valid_next    = 1'b0;
                    since_change_next = '0;
                end
                slpc_pkg::ACT_LINK_DOWN:
                begin
                    link_up_next      = 1'b0;
                    pairing_next      = 1'b0;
                    req_mode_next     = slpc_pkg::MODE_OFF;
                    req_valid_next    = 1'b0;
                    since_change_next = '0;
                end
                slpc_pkg::ACT_PAIR_START: pairing_next = 1'b1;
                slpc_pkg::ACT_PAIR_DONE:  pairing_next = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uptime_reg       <= '0;
            since_write_reg  <= '0;
            since_change_reg <= '0;
            link_up_reg      <= 1'b0;
            pairing_reg      <= 1'b0;
            req_mode_reg     <= slpc_pkg::MODE_OFF;
            req_valid_reg    <= 1'b0;
        end
        else
        begin
            uptime_reg       <= uptime_next;
            since_write_reg  <= since_write_next;
            since_change_reg <= since_change_next;
            link_up_reg      <= link_up_next;
            pairing_reg      <= pairing_next;
            req_mode_reg     <= req_mode_next;
            req_valid_reg    <= req_valid_next;
        end
    end

    // age compares against the configured limits
    always_comb
    begin
        status.uptime         = uptime_reg;
        status.link_up        = link_up_reg;
        status.pairing_active = pairing_reg;
        status.requested_mode = req_mode_reg;
        status.request_valid  = req_valid_reg;
        status.write_fresh    = since_write_reg <= AGE_WIDTH'(stale_timeout);
        status.change_solid   = since_change_reg >= AGE_WIDTH'(waiting_solid);
    end

endmodule
